// File: rtl/mmhr_pkg.sv
package mmhr_pkg;

    // message type field
    localparam int unsigned TYPE_LSB = 52;
    localparam int unsigned TYPE_W   = 8;

    localparam logic [TYPE_W-1:0] MSG_HELLO     = 8'd1;
    localparam logic [TYPE_W-1:0] MSG_HELLO_ACK = 8'd2;
    localparam logic [TYPE_W-1:0] MSG_EPMAP     = 8'd8;

    localparam int unsigned WORD_W = 64;
    localparam int unsigned VER_W  = 16;
    localparam int unsigned EP_W   = 8;
    localparam int unsigned TGT_W  = 6;
    localparam int unsigned BASE_W = 3;

    // register indexes on the configuration port
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_VERSION_MIN     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VERSION_MAX     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_ENDPOINT = 2'd2;

    localparam logic [VER_W-1:0] VERSION_MIN_RST     = 16'd11;
    localparam logic [VER_W-1:0] VERSION_MAX_RST     = 16'd12;
    localparam logic [TGT_W-1:0] TARGET_ENDPOINT_RST = 6'd2;

    // default depth of the queue between decode and execute
    localparam int unsigned MMHR_QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        ST_HANDLED      = 2'd0,
        ST_VER_REJECTED = 2'd1,
        ST_UNHANDLED    = 2'd2,
        ST_OTHER_EP     = 2'd3
    } t_status;

    typedef struct packed {
        logic [VER_W-1:0] version_min;
        logic [VER_W-1:0] version_max;
    } t_ver_cfg;

    // decoded command handed from the front to the back
    typedef struct packed {
        logic              reply_valid;
        logic [WORD_W-1:0] reply_word;
        logic              set_hello;
        logic              set_map_done;
        logic [WORD_W-1:0] map_or;
        t_status           status;
    } t_cmd;

endpackage

// File: rtl/mailbox_mgmt_handshake_responder_unit.sv
// Management handshake responder, host side of a coprocessor mailbox.
// Input channel (i_in_valid / o_in_ready): one received mailbox item,
// i_source_endpoint plus i_message_word. Endpoint 0 carries management
// messages: HELLO, its reply and EPMAP; anything else is reported.
// Output channel (o_out_valid / i_out_ready): exactly one result item per
// input item, in order: reply to send, flags, endpoint map and status.
// Config channel (i_cfg_valid / o_cfg_ready): index 0 version_min,
// 1 version_max, 2 target_endpoint; always ready, write only while idle.
// Path: an item is queued, then moved to the output register. Throughput:
// one item per cycle unless stalled; the decode stage and the state
// update stage each handle one item a cycle, with a small queue between.
// Reset: flags and endpoint map clear, config returns to 11 / 12 / 2,
// queue and output register empty. Stall: a held output register lets the
// queue fill; once it is full o_in_ready drops until the receiver takes
// the waiting result.
module mailbox_mgmt_handshake_responder_unit #(
    parameter int unsigned QUEUE_DEPTH = mmhr_pkg::MMHR_QUEUE_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input items
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [mmhr_pkg::EP_W-1:0]      i_source_endpoint,
    input  logic [mmhr_pkg::WORD_W-1:0]    i_message_word,
    // result items
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_reply_valid,
    output logic [mmhr_pkg::WORD_W-1:0]    o_reply_word,
    output logic                           o_hello_seen,
    output logic                           o_map_complete,
    output logic                           o_session_up,
    output logic [mmhr_pkg::WORD_W-1:0]    o_endpoint_map,
    output logic                           o_target_advertised,
    output logic [1:0]                     o_status,
    // configuration writes
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [mmhr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mmhr_pkg::VER_W-1:0]     i_cfg_data
);
    import mmhr_pkg::*;

    logic [VER_W-1:0] r_version_min;
    logic [VER_W-1:0] r_version_max;
    logic [TGT_W-1:0] r_target_ep;
    t_ver_cfg         ver_cfg;

    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;
    t_cmd q_in_cmd;
    t_cmd q_out_cmd;

    // config registers, writes to unused indexes are dropped
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_version_min <= VERSION_MIN_RST;
            r_version_max <= VERSION_MAX_RST;
            r_target_ep   <= TARGET_ENDPOINT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_VERSION_MIN:     r_version_min <= i_cfg_data;
                CFG_VERSION_MAX:     r_version_max <= i_cfg_data;
                CFG_TARGET_ENDPOINT: r_target_ep   <= i_cfg_data[TGT_W-1:0];
                default: ;
            endcase
        end
    end

    assign ver_cfg.version_min = r_version_min;
    assign ver_cfg.version_max = r_version_max;

    // decode: classify the message and build the reply
    mmhr_front u_front (
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_source_endpoint (i_source_endpoint),
        .i_message_word    (i_message_word),
        .i_ver_cfg         (ver_cfg),
        .i_q_full          (q_full),
        .o_q_push          (q_push),
        .o_q_cmd           (q_in_cmd)
    );

    // decoupling queue between decode and execute
    mmhr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_push_cmd (q_in_cmd),
        .o_full     (q_full),
        .i_pop      (q_pop),
        .o_empty    (q_empty),
        .o_pop_cmd  (q_out_cmd)
    );

    // execute: update session state and register the result
    mmhr_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_q_empty           (q_empty),
        .i_q_cmd             (q_out_cmd),
        .o_q_pop             (q_pop),
        .i_target_endpoint   (r_target_ep),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_reply_valid       (o_reply_valid),
        .o_reply_word        (o_reply_word),
        .o_hello_seen        (o_hello_seen),
        .o_map_complete      (o_map_complete),
        .o_session_up        (o_session_up),
        .o_endpoint_map      (o_endpoint_map),
        .o_target_advertised (o_target_advertised),
        .o_status            (o_status)
    );

endmodule

// File: rtl/mmhr_front.sv
module mmhr_front (
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [mmhr_pkg::EP_W-1:0]    i_source_endpoint,
    input  logic [mmhr_pkg::WORD_W-1:0]  i_message_word,
    input  mmhr_pkg::t_ver_cfg           i_ver_cfg,
    input  logic                         i_q_full,
    output logic                         o_q_push,
    output mmhr_pkg::t_cmd               o_q_cmd
);
    import mmhr_pkg::*;

    logic [TYPE_W-1:0] msg_type;
    logic [VER_W-1:0]  fw_min;
    logic [VER_W-1:0]  fw_max;
    logic [VER_W-1:0]  agreed;
    logic [BASE_W-1:0] base;
    logic [31:0]       bitmap;
    logic              last;

    assign o_in_ready = !i_q_full;
    assign o_q_push   = i_in_valid && !i_q_full;

    assign msg_type = i_message_word[TYPE_LSB +: TYPE_W];
    assign fw_min   = i_message_word[15:0];
    assign fw_max   = i_message_word[31:16];
    assign agreed   = (i_ver_cfg.version_max < fw_max) ? i_ver_cfg.version_max : fw_max;
    assign base     = i_message_word[34:32];
    assign bitmap   = i_message_word[31:0];
    assign last     = i_message_word[51];

    always_comb begin
        o_q_cmd = '0;
        o_q_cmd.status = ST_HANDLED;
        if (i_source_endpoint != '0) begin
            o_q_cmd.status = ST_OTHER_EP;
        end else begin
            case (msg_type)
                MSG_HELLO: begin
                    if (fw_min > i_ver_cfg.version_max || fw_max < i_ver_cfg.version_min) begin
                        o_q_cmd.status = ST_VER_REJECTED;
                    end else begin
                        o_q_cmd.reply_valid = 1'b1;
                        o_q_cmd.reply_word  = {4'b0, MSG_HELLO_ACK, 20'b0, agreed, agreed};
                        o_q_cmd.set_hello   = 1'b1;
                    end
                end
                MSG_HELLO_ACK: begin
                    o_q_cmd.set_hello = 1'b1;
                end
                MSG_EPMAP: begin
                    // bases of two or more fall past the 64-entry map
                    case (base)
                        3'd0:    o_q_cmd.map_or = {32'b0, bitmap};
                        3'd1:    o_q_cmd.map_or = {bitmap, 32'b0};
                        default: o_q_cmd.map_or = '0;
                    endcase
                    o_q_cmd.reply_valid  = 1'b1;
                    o_q_cmd.reply_word   = {4'b0, MSG_EPMAP, last, 16'b0, base, 31'b0, !last};
                    o_q_cmd.set_map_done = last;
                end
                default: begin
                    o_q_cmd.status = ST_UNHANDLED;
                end
            endcase
        end
    end

endmodule

// File: rtl/mmhr_queue.sv
module mmhr_queue #(
    parameter int unsigned DEPTH = mmhr_pkg::MMHR_QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mmhr_pkg::t_cmd i_push_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output mmhr_pkg::t_cmd o_pop_cmd
);
    import mmhr_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_pop_cmd = r_slot[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

// File: rtl/mmhr_back.sv
module mmhr_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_empty,
    input  mmhr_pkg::t_cmd               i_q_cmd,
    output logic                         o_q_pop,
    input  logic [mmhr_pkg::TGT_W-1:0]   i_target_endpoint,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_reply_valid,
    output logic [mmhr_pkg::WORD_W-1:0]  o_reply_word,
    output logic                         o_hello_seen,
    output logic                         o_map_complete,
    output logic                         o_session_up,
    output logic [mmhr_pkg::WORD_W-1:0]  o_endpoint_map,
    output logic                         o_target_advertised,
    output logic [1:0]                   o_status
);
    import mmhr_pkg::*;

    logic              r_hello, n_hello;
    logic              r_map_done, n_map_done;
    logic [WORD_W-1:0] r_map, n_map;
    logic              r_out_valid;

    logic              r_reply_valid;
    logic [WORD_W-1:0] r_reply_word;
    logic              r_target_adv;
    t_status           r_status;

    // output register frees up when empty or taken this cycle
    assign o_q_pop = !i_q_empty && (!r_out_valid || i_out_ready);

    assign n_hello    = r_hello || i_q_cmd.set_hello;
    assign n_map_done = r_map_done || i_q_cmd.set_map_done;
    assign n_map      = r_map | i_q_cmd.map_or;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hello     <= 1'b0;
            r_map_done  <= 1'b0;
            r_map       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_hello    <= n_hello;
                r_map_done <= n_map_done;
                r_map      <= n_map;
            end
            if (o_q_pop) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_reply_valid <= i_q_cmd.reply_valid;
            r_reply_word  <= i_q_cmd.reply_word;
            r_target_adv  <= n_map[i_target_endpoint];
            r_status      <= i_q_cmd.status;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_reply_valid       = r_reply_valid;
    assign o_reply_word        = r_reply_word;
    assign o_hello_seen        = r_hello;
    assign o_map_complete      = r_map_done;
    assign o_session_up        = r_hello && r_map_done;
    assign o_endpoint_map      = r_map;
    assign o_target_advertised = r_target_adv;
    assign o_status            = r_status;

endmodule

// File: tb/sv/mailbox_mgmt_handshake_responder_unit_tb.sv
module mailbox_mgmt_handshake_responder_unit_tb;
    import mmhr_pkg::*;

    // field positions inside a mailbox word
    localparam int unsigned BASE_LSB = 32;
    localparam int unsigned LAST_BIT = 51;
    localparam int unsigned MORE_BIT = 0;

    // register index that maps to nothing, writes to it must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

    localparam int unsigned PHASES          = 6;
    localparam int unsigned ITEMS_PER_PHASE = 75;

    // one result item as the block reports it
    typedef struct packed {
        logic              reply_valid;
        logic [WORD_W-1:0] reply_word;
        logic              hello_seen;
        logic              map_complete;
        logic              session_up;
        logic [WORD_W-1:0] endpoint_map;
        logic              target_advertised;
        t_status           status;
    } t_mgmt_result;

    // one row of the directed messages, with an optional hand-typed result
    typedef struct {
        logic [EP_W-1:0]   ep;
        logic [WORD_W-1:0] word;
        bit                typed;
        t_mgmt_result      want;
    } t_msg_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [EP_W-1:0]       i_source_endpoint;
    logic [WORD_W-1:0]     i_message_word;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic                  o_reply_valid;
    logic [WORD_W-1:0]     o_reply_word;
    logic                  o_hello_seen;
    logic                  o_map_complete;
    logic                  o_session_up;
    logic [WORD_W-1:0]     o_endpoint_map;
    logic                  o_target_advertised;
    logic [1:0]            o_status;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [VER_W-1:0]      i_cfg_data;

    mailbox_mgmt_handshake_responder_unit i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_source_endpoint  (i_source_endpoint),
        .i_message_word     (i_message_word),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_reply_valid      (o_reply_valid),
        .o_reply_word       (o_reply_word),
        .o_hello_seen       (o_hello_seen),
        .o_map_complete     (o_map_complete),
        .o_session_up       (o_session_up),
        .o_endpoint_map     (o_endpoint_map),
        .o_target_advertised(o_target_advertised),
        .o_status           (o_status),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    // shadow of the block's registers and session state
    logic [VER_W-1:0]  ver_min;
    logic [VER_W-1:0]  ver_max;
    logic [TGT_W-1:0]  tgt_ep;
    logic              hello_ok;
    logic              map_done;
    logic [WORD_W-1:0] adv_map;

    // results still owed by the block, oldest first
    t_mgmt_result expected_results[$];
    t_mgmt_result arrived_want;
    int           mismatches;

    // idle rates in percent, changed by the main sequence
    int sender_idle_pct;
    int receiver_stall_pct;

    t_msg_row    directed_msgs[$];
    logic [15:0] phase_min[PHASES];
    logic [15:0] phase_max[PHASES];
    logic [15:0] phase_tgt[PHASES];

    // 2 time unit clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // the management decode: updates the shadow state, returns the result item
    task automatic respond_to_message(input logic [EP_W-1:0] ep,
                                      input logic [WORD_W-1:0] w,
                                      output t_mgmt_result r);
        logic [VER_W-1:0]  fw_min;
        logic [VER_W-1:0]  fw_max;
        logic [VER_W-1:0]  agreed;
        logic [BASE_W-1:0] base;
        logic [TYPE_W-1:0] kind;
        r = '0;
        kind = w[TYPE_LSB +: TYPE_W];
        if (ep != '0) begin
            r.status = ST_OTHER_EP;
        end else if (kind == MSG_HELLO) begin
            fw_min = w[15:0];
            fw_max = w[31:16];
            // plain comparisons, even when the configured window is inverted
            if (fw_min > ver_max || fw_max < ver_min) begin
                r.status = ST_VER_REJECTED;
            end else begin
                agreed = (ver_max < fw_max) ? ver_max : fw_max;
                r.reply_valid = 1'b1;
                r.reply_word[TYPE_LSB +: TYPE_W] = MSG_HELLO_ACK;
                r.reply_word[31:16] = agreed;
                r.reply_word[15:0] = agreed;
                hello_ok = 1'b1;
                r.status = ST_HANDLED;
            end
        end else if (kind == MSG_HELLO_ACK) begin
            hello_ok = 1'b1;
            r.status = ST_HANDLED;
        end else if (kind == MSG_EPMAP) begin
            base = w[BASE_LSB +: BASE_W];
            // only the first two 32-entry windows exist, higher bases are echoed only
            if (base == 0)
                adv_map[31:0] = adv_map[31:0] | w[31:0];
            else if (base == 1)
                adv_map[63:32] = adv_map[63:32] | w[31:0];
            r.reply_valid = 1'b1;
            r.reply_word[TYPE_LSB +: TYPE_W] = MSG_EPMAP;
            r.reply_word[BASE_LSB +: BASE_W] = base;
            if (w[LAST_BIT]) begin
                r.reply_word[LAST_BIT] = 1'b1;
                map_done = 1'b1;
            end else begin
                r.reply_word[MORE_BIT] = 1'b1;
            end
            r.status = ST_HANDLED;
        end else begin
            r.status = ST_UNHANDLED;
        end
        r.hello_seen = hello_ok;
        r.map_complete = map_done;
        r.session_up = hello_ok & map_done;
        r.endpoint_map = adv_map;
        r.target_advertised = adv_map[tgt_ep];
    endtask

    function automatic t_msg_row plain_row(input logic [EP_W-1:0] ep,
                                           input logic [WORD_W-1:0] w);
        t_msg_row r;
        r.ep = ep;
        r.word = w;
        r.typed = 1'b0;
        r.want = '0;
        return r;
    endfunction

    function automatic t_msg_row typed_row(input logic [EP_W-1:0] ep,
                                           input logic [WORD_W-1:0] w,
                                           input logic rv, input logic [WORD_W-1:0] rw,
                                           input logic hs, input logic mc, input logic su,
                                           input logic [WORD_W-1:0] em, input logic ta,
                                           input t_status st);
        t_msg_row r;
        r.ep = ep;
        r.word = w;
        r.typed = 1'b1;
        r.want.reply_valid = rv;
        r.want.reply_word = rw;
        r.want.hello_seen = hs;
        r.want.map_complete = mc;
        r.want.session_up = su;
        r.want.endpoint_map = em;
        r.want.target_advertised = ta;
        r.want.status = st;
        return r;
    endfunction

    // offer one item, possibly after random idle cycles; entered at a falling edge
    task automatic send_message(input logic [EP_W-1:0] ep, input logic [WORD_W-1:0] w,
                                input bit typed, input t_mgmt_result want);
        t_mgmt_result predicted;
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_source_endpoint = ep;
        i_message_word = w;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        respond_to_message(ep, w, predicted);
        expected_results.push_back(typed ? want : predicted);
        @(negedge i_clk);
    endtask

    // stop sending and wait for every owed result, then idle before returning
    task automatic settle_queue();
        i_in_valid = 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [VER_W-1:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_VERSION_MIN:     ver_min = data;
            CFG_VERSION_MAX:     ver_max = data;
            CFG_TARGET_ENDPOINT: tgt_ep = data[TGT_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // versions clustered on the edges of the configured window
    function automatic logic [VER_W-1:0] near_version();
        case ($urandom_range(8))
            0: return ver_min - 1'b1;
            1: return ver_min;
            2: return ver_min + 1'b1;
            3: return ver_max - 1'b1;
            4: return ver_max;
            5: return ver_max + 1'b1;
            6: return '0;
            7: return '1;
            default: return VER_W'($urandom);
        endcase
    endfunction

    // mostly well-formed management traffic, with junk in the unused bits
    task automatic random_message(output logic [EP_W-1:0] ep, output logic [WORD_W-1:0] w);
        int          pick;
        logic [31:0] bitmap;
        pick = $urandom_range(99);
        ep = '0;
        w = {$urandom, $urandom};
        if (pick < 10) begin
            ep = EP_W'($urandom_range(255, 1));
        end else if (pick < 20) begin
            // unknown types only
            w[TYPE_LSB +: TYPE_W] = TYPE_W'($urandom);
            while (w[TYPE_LSB +: TYPE_W] == MSG_HELLO || w[TYPE_LSB +: TYPE_W] == MSG_HELLO_ACK
                   || w[TYPE_LSB +: TYPE_W] == MSG_EPMAP)
                w[TYPE_LSB +: TYPE_W] = TYPE_W'($urandom);
        end else if (pick < 50) begin
            w[TYPE_LSB +: TYPE_W] = MSG_HELLO;
            w[15:0] = near_version();
            w[31:16] = near_version();
        end else if (pick < 60) begin
            w[TYPE_LSB +: TYPE_W] = MSG_HELLO_ACK;
        end else begin
            w[TYPE_LSB +: TYPE_W] = MSG_EPMAP;
            // sparse bitmaps so the map fills slowly
            case ($urandom_range(7))
                0, 1, 2, 3: bitmap = 32'd1 << $urandom_range(31);
                4:          bitmap = $urandom;
                5:          bitmap = $urandom & $urandom & $urandom;
                default:    bitmap = '0;
            endcase
            w[31:0] = bitmap;
            w[BASE_LSB +: BASE_W] = ($urandom_range(3) == 0) ? BASE_W'($urandom_range(7))
                                                             : BASE_W'($urandom_range(1));
        end
    endtask

    task automatic compare_field(input string name, input logic [WORD_W-1:0] want,
                                 input logic [WORD_W-1:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on %s: expected %h, got %h", name, want, got);
        end
    endtask

    // result checker: every accepted result against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result item arrived with nothing expected, status %0d", o_status);
            end else begin
                arrived_want = expected_results.pop_front();
                compare_field("reply_valid", WORD_W'(arrived_want.reply_valid),
                              WORD_W'(o_reply_valid));
                compare_field("reply_word", arrived_want.reply_word, o_reply_word);
                compare_field("hello_seen", WORD_W'(arrived_want.hello_seen),
                              WORD_W'(o_hello_seen));
                compare_field("map_complete", WORD_W'(arrived_want.map_complete),
                              WORD_W'(o_map_complete));
                compare_field("session_up", WORD_W'(arrived_want.session_up),
                              WORD_W'(o_session_up));
                compare_field("endpoint_map", arrived_want.endpoint_map, o_endpoint_map);
                compare_field("target_advertised", WORD_W'(arrived_want.target_advertised),
                              WORD_W'(o_target_advertised));
                compare_field("status", WORD_W'(arrived_want.status), WORD_W'(o_status));
            end
        end
    end

    // receiver: random back-pressure, redrawn every cycle
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_out_ready = ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // main sequence
    initial begin
        logic [EP_W-1:0]   rnd_ep;
        logic [WORD_W-1:0] rnd_word;

        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_source_endpoint = '0;
        i_message_word = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_VERSION_MIN;
        i_cfg_data = '0;
        mismatches = 0;
        sender_idle_pct = 22;
        receiver_stall_pct = 57;

        ver_min = VERSION_MIN_RST;
        ver_max = VERSION_MAX_RST;
        tgt_ep = TARGET_ENDPOINT_RST;
        hello_ok = 1'b0;
        map_done = 1'b0;
        adv_map = '0;

        // directed rows; the hand-typed ones run on reset state and reset registers
        // foreign endpoint with every bit set
        directed_msgs.push_back(typed_row(8'hFF, 64'hFFFF_FFFF_FFFF_FFFF,
                                          1'b0, '0, 1'b0, 1'b0, 1'b0, '0, 1'b0,
                                          ST_OTHER_EP));
        // unknown types: all ones and all zeros
        directed_msgs.push_back(typed_row(8'h00, 64'h0FF0_0000_0000_0000,
                                          1'b0, '0, 1'b0, 1'b0, 1'b0, '0, 1'b0,
                                          ST_UNHANDLED));
        directed_msgs.push_back(typed_row(8'h00, 64'h0000_0000_0000_0000,
                                          1'b0, '0, 1'b0, 1'b0, 1'b0, '0, 1'b0,
                                          ST_UNHANDLED));
        // hello rejected: firmware window above, then below 11..12
        directed_msgs.push_back(typed_row(8'h00, 64'h0010_0000_0014_000D,
                                          1'b0, '0, 1'b0, 1'b0, 1'b0, '0, 1'b0,
                                          ST_VER_REJECTED));
        directed_msgs.push_back(typed_row(8'h00, 64'h0010_0000_000A_0000,
                                          1'b0, '0, 1'b0, 1'b0, 1'b0, '0, 1'b0,
                                          ST_VER_REJECTED));
        // hello 11..12 with junk in the unused bits, answered with 12
        directed_msgs.push_back(typed_row(8'h00, 64'hF01F_FFFF_000C_000B,
                                          1'b1, 64'h0020_0000_000C_000C, 1'b1, 1'b0, 1'b0,
                                          '0, 1'b0, ST_HANDLED));
        // widest firmware window
        directed_msgs.push_back(plain_row(8'h00, 64'h0010_0000_FFFF_0000));
        // hello touching each edge, and a firmware window given backwards
        directed_msgs.push_back(plain_row(8'h00, 64'h0010_0000_000C_000C));
        directed_msgs.push_back(plain_row(8'h00, 64'h0010_0000_000B_0000));
        directed_msgs.push_back(plain_row(8'h00, 64'h0010_0000_000B_000C));
        // hello reply, bare and with every other bit set
        directed_msgs.push_back(plain_row(8'h00, 64'h0020_0000_0000_0000));
        directed_msgs.push_back(plain_row(8'h00, 64'hF02F_FFFF_FFFF_FFFF));
        // map: low window full, high window one bit, base 2 dropped
        directed_msgs.push_back(plain_row(8'h00, 64'h0080_0000_FFFF_FFFF));
        directed_msgs.push_back(plain_row(8'h00, 64'h0080_0001_0000_0001));
        directed_msgs.push_back(plain_row(8'h00, 64'h0080_0002_FFFF_FFFF));
        // last flag on base 7 with junk above, then a map item after last
        directed_msgs.push_back(plain_row(8'h00, 64'hF08F_FFFF_0000_0000));
        directed_msgs.push_back(plain_row(8'h00, 64'h0088_0001_8000_0000));
        // management types on other endpoints are ignored
        directed_msgs.push_back(plain_row(8'h01, 64'h0010_0000_000C_000B));
        directed_msgs.push_back(plain_row(8'h80, 64'h0088_0001_FFFF_FFFF));
        // types that only look like known ones
        directed_msgs.push_back(plain_row(8'h00, 64'h0810_0000_000C_000B));
        directed_msgs.push_back(plain_row(8'h00, 64'h0180_0000_FFFF_FFFF));

        // register settings per random phase: wide, pinned low, pinned high,
        // inverted, random, back to reset values
        phase_min = '{16'h0000, 16'h0000, 16'hFFFF, 16'd500, 16'h0000, 16'd11};
        phase_max = '{16'hFFFF, 16'h0000, 16'hFFFF, 16'd100, 16'h0000, 16'd12};
        phase_tgt = '{16'hFFFF, 16'h0000, 16'd31,   16'd40,  16'h0000, 16'd2};
        phase_min[4] = VER_W'($urandom);
        phase_max[4] = VER_W'($urandom);
        phase_tgt[4] = VER_W'($urandom);

        // synchronous reset, released on a falling edge
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (directed_msgs[i])
            send_message(directed_msgs[i].ep, directed_msgs[i].word,
                         directed_msgs[i].typed, directed_msgs[i].want);

        for (int phase = 0; phase < PHASES; phase++) begin
            settle_queue();
            if (phase == 0)
                write_register(CFG_IDX_UNUSED, 16'hFFFF);
            write_register(CFG_VERSION_MIN, phase_min[phase]);
            write_register(CFG_VERSION_MAX, phase_max[phase]);
            write_register(CFG_TARGET_ENDPOINT, phase_tgt[phase]);
            // idle pattern: sender-light first, then receiver-light, then none
            case (phase / 2)
                0: begin
                    sender_idle_pct = 22;
                    receiver_stall_pct = 57;
                end
                1: begin
                    sender_idle_pct = 57;
                    receiver_stall_pct = 22;
                end
                default: begin
                    sender_idle_pct = 0;
                    receiver_stall_pct = 0;
                end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // one mid-phase pause until the block has caught up completely
                if (phase == 2 && n == 40)
                    settle_queue();
                random_message(rnd_ep, rnd_word);
                send_message(rnd_ep, rnd_word, 1'b0, '0);
            end
        end

        settle_queue();
        if (mismatches == 0 && expected_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
